### hw/rtl/stream_engine_window_decoder_top_defines.svh
// Assertion macros for the stream engine window decoder.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef STREAM_ENGINE_WINDOW_DECODER_TOP_DEFINES_SVH
`define STREAM_ENGINE_WINDOW_DECODER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SEWD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sewd: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SEWD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sewd: next-cycle check failed");

`endif

### hw/rtl/sewd_pkg.sv
// Types and fixed constants for the stream engine window decoder.
// No dependencies; used by sewd_decode and the top level.
package sewd_pkg;

    localparam int unsigned CHANNEL_W   = 5;
    localparam int unsigned OFFSET_W    = 20;
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned OUT_W       = 16;
    localparam int unsigned CHL_W       = 3;
    localparam int unsigned MEL_W       = 4;
    localparam int unsigned WIN_W       = 20;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 20;
    // internal offset width: covers every offset for any legal parameter set
    localparam int unsigned ADDR_W      = 32;

    localparam int unsigned MAP_TABLE_LIMIT  = 32768;
    localparam int unsigned QUEUE_ALIGN_MASK = 63;
    localparam int unsigned PAGE_WORD_GAP    = 8;

    localparam logic [CHL_W-1:0] CHL_MIN = 3'd3;
    localparam logic [CHL_W-1:0] CHL_MAX = 3'd5;
    localparam logic [MEL_W-1:0] MEL_MIN = 4'd3;
    localparam logic [MEL_W-1:0] MEL_MAX = 4'd10;

    localparam logic [CHL_W-1:0] CHL_RESET = 3'd3;
    localparam logic [MEL_W-1:0] MEL_RESET = 4'd3;
    localparam logic [WIN_W-1:0] WIN_RESET = 20'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT_LOG   = 2'd0,
        CFG_MAP_ENTRY_COUNT_LOG = 2'd1,
        CFG_WINDOW_SIZE         = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DENIED  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        RG_NONE    = 3'd0,
        RG_MAP     = 3'd1,
        RG_CONTROL = 3'd2,
        RG_BELOW   = 3'd3,
        RG_PAGE    = 3'd4
    } t_region;

    typedef struct packed {
        logic [CHL_W-1:0] channel_count_log;
        logic [MEL_W-1:0] map_entry_count_log;
        logic [WIN_W-1:0] window_size;
    } t_cfg;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [OFFSET_W-1:0]  offset;
        logic [COUNT_W-1:0]   byte_count;
        logic                 is_write;
    } t_req;

    typedef struct packed {
        t_status          status;
        t_region          region;
        logic             aggregate;
        logic [OUT_W-1:0] map_start;
        logic [OUT_W-1:0] map_end;
        logic [OUT_W-1:0] control_start;
        logic [OUT_W-1:0] page_word;
        logic [OUT_W-1:0] request_queue_start;
        logic [OUT_W-1:0] completion_queue_start;
        logic [OUT_W-1:0] request_head_tail;
        logic [OUT_W-1:0] completion_head_tail;
    } t_result;

endpackage

### hw/rtl/sewd_decode.sv
// Combinational address-map decode and access check for one request.
// Depends on sewd_pkg.
module sewd_decode #(
    parameter int unsigned MAP_ENTRY_BYTES     = 32,
    parameter int unsigned SHARED_ENTRY_BYTES  = 16,
    parameter int unsigned CONTROL_BYTES       = 64,
    parameter int unsigned QUEUE_DEPTH         = 8,
    parameter int unsigned QUEUE_ELEMENT_BYTES = 32,
    parameter int unsigned HEAD_TAIL_BYTES     = 8
) (
    input  sewd_pkg::t_cfg    i_cfg,
    input  sewd_pkg::t_req    i_req,
    output sewd_pkg::t_result o_result
);

    localparam int unsigned AW        = sewd_pkg::ADDR_W;
    localparam int unsigned OW        = sewd_pkg::OUT_W;
    localparam int unsigned QPAIR     = 2 * QUEUE_DEPTH * QUEUE_ELEMENT_BYTES;
    localparam int unsigned QBYTES    = QUEUE_DEPTH * QUEUE_ELEMENT_BYTES;
    localparam int unsigned HTPAIR    = 2 * HEAD_TAIL_BYTES;

    logic [sewd_pkg::CHL_W-1:0] chl;
    logic [sewd_pkg::MEL_W-1:0] mel;
    logic [4:0]    map_sh;
    logic [AW-1:0] ch, chn, ofs, ofs_end, cnt;
    logic [AW-1:0] mstart, mend, cbase, cstart, cend, page, qbase, htbase;
    logic [AW-1:0] rq, cq, rht, cht;
    logic          agg, bad, in_map, in_ctl, below, at_page, cnt4;
    sewd_pkg::t_region region;

    always_comb begin
        if (i_cfg.channel_count_log < sewd_pkg::CHL_MIN) begin
            chl = sewd_pkg::CHL_MIN;
        end else if (i_cfg.channel_count_log > sewd_pkg::CHL_MAX) begin
            chl = sewd_pkg::CHL_MAX;
        end else begin
            chl = i_cfg.channel_count_log;
        end
        if (i_cfg.map_entry_count_log < sewd_pkg::MEL_MIN) begin
            mel = sewd_pkg::MEL_MIN;
        end else if (i_cfg.map_entry_count_log > sewd_pkg::MEL_MAX) begin
            mel = sewd_pkg::MEL_MAX;
        end else begin
            mel = i_cfg.map_entry_count_log;
        end
    end

    assign map_sh  = 5'(chl) + 5'(mel);
    assign ch      = AW'(i_req.channel);
    assign chn     = AW'(1) << chl;
    assign ofs     = AW'(i_req.offset);
    assign cnt     = AW'(i_req.byte_count);
    assign ofs_end = ofs + cnt;

    // entry counts are powers of two, so every table size is a shift
    assign agg    = (AW'(MAP_ENTRY_BYTES) << map_sh) > AW'(sewd_pkg::MAP_TABLE_LIMIT);
    assign mstart = agg ? '0 : ((AW'(MAP_ENTRY_BYTES) * ch) << mel);
    assign mend   = agg ? (AW'(SHARED_ENTRY_BYTES) << mel)
                        : ((AW'(MAP_ENTRY_BYTES) * (ch + AW'(1))) << mel);
    assign cbase  = agg ? (AW'(SHARED_ENTRY_BYTES) << mel)
                        : (AW'(MAP_ENTRY_BYTES) << map_sh);
    assign cstart = cbase + AW'(CONTROL_BYTES) * ch;
    assign cend   = cstart + AW'(CONTROL_BYTES);
    assign page   = cbase + (AW'(CONTROL_BYTES) << chl) + AW'(sewd_pkg::PAGE_WORD_GAP);

    assign qbase  = (page + AW'(sewd_pkg::QUEUE_ALIGN_MASK))
                    & ~AW'(sewd_pkg::QUEUE_ALIGN_MASK);
    assign htbase = qbase + (AW'(QPAIR) << chl);
    assign rq     = qbase + AW'(QPAIR) * ch;
    assign cq     = rq + AW'(QBYTES);
    assign rht    = htbase + AW'(HTPAIR) * ch;
    assign cht    = rht + AW'(HEAD_TAIL_BYTES);

    assign cnt4    = (i_req.byte_count == sewd_pkg::COUNT_W'(4));
    assign bad     = (ofs_end > AW'(i_cfg.window_size)) || (i_req.byte_count[1:0] != 2'd0)
                     || (ch >= chn);
    assign in_map  = (mstart <= ofs) && (ofs_end <= mend);
    assign in_ctl  = (cstart <= ofs) && (ofs_end <= cend);
    assign below   = cnt4 && (ofs == page - AW'(sewd_pkg::PAGE_WORD_GAP));
    assign at_page = cnt4 && (ofs == page);

    // first match wins; writes only reach the control block and the word below
    always_comb begin
        region = sewd_pkg::RG_NONE;
        if (!bad) begin
            if (!i_req.is_write && in_map) begin
                region = sewd_pkg::RG_MAP;
            end else if (in_ctl) begin
                region = sewd_pkg::RG_CONTROL;
            end else if (below) begin
                region = sewd_pkg::RG_BELOW;
            end else if (!i_req.is_write && at_page) begin
                region = sewd_pkg::RG_PAGE;
            end
        end
    end

    always_comb begin
        if (bad) begin
            o_result.status = sewd_pkg::ST_INVALID;
        end else if (region == sewd_pkg::RG_NONE) begin
            o_result.status = sewd_pkg::ST_DENIED;
        end else begin
            o_result.status = sewd_pkg::ST_OK;
        end
        o_result.region                 = region;
        o_result.aggregate              = agg;
        o_result.map_start              = mstart[OW-1:0];
        o_result.map_end                = mend[OW-1:0];
        o_result.control_start          = cstart[OW-1:0];
        o_result.page_word              = page[OW-1:0];
        o_result.request_queue_start    = rq[OW-1:0];
        o_result.completion_queue_start = cq[OW-1:0];
        o_result.request_head_tail      = rht[OW-1:0];
        o_result.completion_head_tail   = cht[OW-1:0];
    end

endmodule

### hw/rtl/stream_engine_window_decoder_top.sv
// A result passes through the input register, then decode into the result
// register. Throughput: one request per cycle, set by the single decode stage
// between the two registers; the pipeline only holds when the result side
// stalls. Reset clears both stage valids and loads channel_count_log 3,
// map_entry_count_log 3, window_size 65536.
// Depends on sewd_pkg, sewd_decode and the defines header.
`include "stream_engine_window_decoder_top_defines.svh"

module stream_engine_window_decoder_top #(
    parameter int unsigned MAP_ENTRY_BYTES     = 32,
    parameter int unsigned SHARED_ENTRY_BYTES  = 16,
    parameter int unsigned CONTROL_BYTES       = 64,
    parameter int unsigned QUEUE_DEPTH         = 8,
    parameter int unsigned QUEUE_ELEMENT_BYTES = 32,
    parameter int unsigned HEAD_TAIL_BYTES     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sewd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sewd_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sewd_pkg::CHANNEL_W-1:0]      i_channel,
    input  logic [sewd_pkg::OFFSET_W-1:0]       i_offset,
    input  logic [sewd_pkg::COUNT_W-1:0]        i_byte_count,
    input  logic                                i_is_write,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic [2:0]                          o_region,
    output logic                                o_aggregate,
    output logic [sewd_pkg::OUT_W-1:0]          o_map_start,
    output logic [sewd_pkg::OUT_W-1:0]          o_map_end,
    output logic [sewd_pkg::OUT_W-1:0]          o_control_start,
    output logic [sewd_pkg::OUT_W-1:0]          o_page_word,
    output logic [sewd_pkg::OUT_W-1:0]          o_request_queue_start,
    output logic [sewd_pkg::OUT_W-1:0]          o_completion_queue_start,
    output logic [sewd_pkg::OUT_W-1:0]          o_request_head_tail,
    output logic [sewd_pkg::OUT_W-1:0]          o_completion_head_tail
);

    sewd_pkg::t_cfg    r_cfg, n_cfg;
    sewd_pkg::t_req    r_req;
    sewd_pkg::t_result r_res;
    sewd_pkg::t_result dec_res;
    logic              r_v1, r_v2;
    logic              adv2, adv1;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (sewd_pkg::t_cfg_index'(i_cfg_index))
                sewd_pkg::CFG_CHANNEL_COUNT_LOG: begin
                    n_cfg.channel_count_log = i_cfg_data[sewd_pkg::CHL_W-1:0];
                end
                sewd_pkg::CFG_MAP_ENTRY_COUNT_LOG: begin
                    n_cfg.map_entry_count_log = i_cfg_data[sewd_pkg::MEL_W-1:0];
                end
                sewd_pkg::CFG_WINDOW_SIZE: begin
                    n_cfg.window_size = i_cfg_data[sewd_pkg::WIN_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count_log   <= sewd_pkg::CHL_RESET;
            r_cfg.map_entry_count_log <= sewd_pkg::MEL_RESET;
            r_cfg.window_size         <= sewd_pkg::WIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // stage 2 moves when empty or its result is taken; stage 1 moves into it
    assign adv2       = !r_v2 || i_out_ready;
    assign adv1       = !r_v1 || adv2;
    assign o_in_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_in_valid) begin
            r_req.channel    <= i_channel;
            r_req.offset     <= i_offset;
            r_req.byte_count <= i_byte_count;
            r_req.is_write   <= i_is_write;
        end
        if (adv2 && r_v1) begin
            r_res <= dec_res;
        end
    end

    sewd_decode #(
        .MAP_ENTRY_BYTES     (MAP_ENTRY_BYTES),
        .SHARED_ENTRY_BYTES  (SHARED_ENTRY_BYTES),
        .CONTROL_BYTES       (CONTROL_BYTES),
        .QUEUE_DEPTH         (QUEUE_DEPTH),
        .QUEUE_ELEMENT_BYTES (QUEUE_ELEMENT_BYTES),
        .HEAD_TAIL_BYTES     (HEAD_TAIL_BYTES)
    ) u_decode (
        .i_cfg    (r_cfg),
        .i_req    (r_req),
        .o_result (dec_res)
    );

    assign o_out_valid              = r_v2;
    assign o_status                 = r_res.status;
    assign o_region                 = r_res.region;
    assign o_aggregate              = r_res.aggregate;
    assign o_map_start              = r_res.map_start;
    assign o_map_end                = r_res.map_end;
    assign o_control_start          = r_res.control_start;
    assign o_page_word              = r_res.page_word;
    assign o_request_queue_start    = r_res.request_queue_start;
    assign o_completion_queue_start = r_res.completion_queue_start;
    assign o_request_head_tail      = r_res.request_head_tail;
    assign o_completion_head_tail   = r_res.completion_head_tail;

    // allowed accesses always name a region, denied ones never do
    `SEWD_ASSERT_IMP(a_ok_has_region, o_out_valid && (r_res.status == sewd_pkg::ST_OK), r_res.region != sewd_pkg::RG_NONE)
    `SEWD_ASSERT_IMP(a_deny_no_region, o_out_valid && (r_res.status != sewd_pkg::ST_OK), r_res.region == sewd_pkg::RG_NONE)
    // shared table starts at zero for every channel
    `SEWD_ASSERT_IMP(a_agg_map_zero, o_out_valid && r_res.aggregate, r_res.map_start == '0)
    // a transfer always lands in the input stage
    `SEWD_ASSERT_NXT(a_in_lands, i_in_valid && o_in_ready, r_v1)

endmodule
